[rtl/core/b64enc_pkg.sv]
// ----------------------------------------------------------------------------
// b64enc_pkg
// Shared types, constants and the sextet-to-character mapping for the base64
// stream encoder.
// ----------------------------------------------------------------------------
package b64enc_pkg;

	localparam int unsigned GqDepthDefault = 2;
	localparam int unsigned CfgIdxW = 2;

	localparam logic       CMD_DATA  = 1'b0;
	localparam logic       CMD_FLUSH = 1'b1;

	localparam logic [CfgIdxW-1:0] REG_URL_ALPHABET = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_PAD_ENABLE   = 2'd1;

	localparam logic [6:0] PAD_CHAR   = 7'h3D;
	localparam logic [6:0] CHAR_PLUS  = 7'h2B;
	localparam logic [6:0] CHAR_SLASH = 7'h2F;
	localparam logic [6:0] CHAR_DASH  = 7'h2D;
	localparam logic [6:0] CHAR_UNDER = 7'h5F;
	localparam logic [6:0] CHAR_UPPER_A = 7'h41;
	localparam logic [6:0] CHAR_LOWER_A = 7'h61;
	localparam logic [6:0] CHAR_ZERO    = 7'h30;

	typedef struct packed {
		logic       cmd;
		logic [7:0] data_byte;
	} b64_in_t;

	typedef struct packed {
		logic [6:0] out_char;
		logic       last;
	} b64_out_t;

	typedef struct packed {
		logic url_alphabet;
		logic pad_enable;
	} b64_cfg_t;

	// One group of one to three bytes; unused bytes are zero.
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [1:0] n;
	} b64_group_t;

	function automatic logic [6:0] sextet_char(input logic [5:0] v, input logic url);
		logic [6:0] ch;
		priority if (v < 6'd26) begin
			ch = CHAR_UPPER_A + 7'(v);
		end else if (v < 6'd52) begin
			ch = CHAR_LOWER_A + 7'(v - 6'd26);
		end else if (v < 6'd62) begin
			ch = CHAR_ZERO + 7'(v - 6'd52);
		end else if (v == 6'd62) begin
			ch = url ? CHAR_DASH : CHAR_PLUS;
		end else begin
			ch = url ? CHAR_UNDER : CHAR_SLASH;
		end
		return ch;
	endfunction

endpackage

[rtl/core/b64enc_front.sv]
// ----------------------------------------------------------------------------
// b64enc_front
// Accepts input items, holds the first two bytes of a group and hands a
// complete or flushed group to the group queue.
// ----------------------------------------------------------------------------
module b64enc_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  b64enc_pkg::b64_in_t   byte_item,
	output logic                  gq_wr,
	output b64enc_pkg::b64_group_t gq_wdata,
	input  logic                  gq_full
);
	import b64enc_pkg::*;

	logic [1:0] held_count_q;
	logic [7:0] held0_q;
	logic [7:0] held1_q;
	logic       accept;
	logic [1:0] count;

	assign full   = gq_full;
	assign accept = push && !gq_full;
	// A count of three cannot arise; treat it as empty.
	assign count  = (held_count_q == 2'd3) ? 2'd0 : held_count_q;

	always_comb begin
		gq_wdata.b0 = held0_q;
		gq_wdata.b1 = (count == 2'd2) ? held1_q : 8'd0;
		gq_wdata.b2 = 8'd0;
		gq_wdata.n  = count;
		gq_wr       = 1'b0;
		if (accept) begin
			if (byte_item.cmd == CMD_FLUSH) begin
				gq_wr = (count != 2'd0);
			end else if (count == 2'd2) begin
				gq_wr       = 1'b1;
				gq_wdata.b2 = byte_item.data_byte;
				gq_wdata.n  = 2'd3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= 2'd0;
		end else if (accept) begin
			if (byte_item.cmd == CMD_FLUSH || count == 2'd2) begin
				held_count_q <= 2'd0;
			end else begin
				held_count_q <= count + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && byte_item.cmd == CMD_DATA) begin
			if (count == 2'd0) begin
				held0_q <= byte_item.data_byte;
			end
			if (count == 2'd1) begin
				held1_q <= byte_item.data_byte;
			end
		end
	end

endmodule

[rtl/core/b64enc_gq.sv]
// ----------------------------------------------------------------------------
// b64enc_gq
// Short queue of byte groups between the front and the character back end.
// ----------------------------------------------------------------------------
module b64enc_gq #(
	parameter int unsigned Depth = b64enc_pkg::GqDepthDefault
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr,
	input  b64enc_pkg::b64_group_t wdata,
	input  logic                   rd,
	output b64enc_pkg::b64_group_t rdata,
	output logic                   gq_full,
	output logic                   gq_empty
);
	import b64enc_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

	b64_group_t          mem_q [Depth];
	logic [PtrW-1:0]     wptr_q;
	logic [PtrW-1:0]     rptr_q;
	logic [CntW-1:0]     cnt_q;
	logic                do_wr;
	logic                do_rd;

	assign gq_full  = (cnt_q == CntW'(Depth));
	assign gq_empty = (cnt_q == '0);
	assign do_wr    = wr && !gq_full;
	assign do_rd    = rd && !gq_empty;
	assign rdata    = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

[rtl/core/b64enc_back.sv]
// ----------------------------------------------------------------------------
// b64enc_back
// Takes groups from the queue and emits their characters one per cycle into
// an output register, holding while that register is full and not popped.
// ----------------------------------------------------------------------------
module b64enc_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  b64enc_pkg::b64_cfg_t   cfg,
	input  b64enc_pkg::b64_group_t gq_rdata,
	input  logic                   gq_empty,
	output logic                   gq_rd,
	output logic                   empty,
	input  logic                   pop,
	output b64enc_pkg::b64_out_t   char_item
);
	import b64enc_pkg::*;

	b64_group_t grp_q;
	logic       cur_valid_q;
	logic [1:0] idx_q;
	logic       out_valid_q;
	b64_out_t   out_q;

	logic       slot_free;
	logic       adv;
	logic       finish;
	logic [1:0] last_idx;
	logic [5:0] s0, s1, s2, s3;
	b64_out_t   ch;

	assign s0 = grp_q.b0[7:2];
	assign s1 = {grp_q.b0[1:0], grp_q.b1[7:4]};
	assign s2 = {grp_q.b1[3:0], grp_q.b2[7:6]};
	assign s3 = grp_q.b2[5:0];

	// Full groups and padded partial groups give four characters; an
	// unpadded partial group gives one more than its byte count.
	assign last_idx  = (grp_q.n == 2'd3 || cfg.pad_enable) ? 2'd3 : grp_q.n;
	assign slot_free = !out_valid_q || pop;
	assign adv       = cur_valid_q && slot_free;
	assign finish    = adv && (idx_q == last_idx);
	assign gq_rd     = !gq_empty && (!cur_valid_q || finish);

	always_comb begin
		ch.last = (idx_q == last_idx);
		unique case (idx_q)
			2'd0: ch.out_char = sextet_char(s0, cfg.url_alphabet);
			2'd1: ch.out_char = sextet_char(s1, cfg.url_alphabet);
			2'd2: ch.out_char = (grp_q.n >= 2'd2) ? sextet_char(s2, cfg.url_alphabet)
			                                      : PAD_CHAR;
			2'd3: ch.out_char = (grp_q.n == 2'd3) ? sextet_char(s3, cfg.url_alphabet)
			                                      : PAD_CHAR;
			default: ch.out_char = PAD_CHAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (gq_rd) begin
				cur_valid_q <= 1'b1;
				idx_q       <= 2'd0;
			end else if (finish) begin
				cur_valid_q <= 1'b0;
				idx_q       <= 2'd0;
			end else if (adv) begin
				idx_q <= idx_q + 2'd1;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (gq_rd) begin
			grp_q <= gq_rdata;
		end
		if (adv) begin
			out_q <= ch;
		end
	end

	assign empty     = !out_valid_q;
	assign char_item = out_q;

endmodule

[rtl/core/base64_stream_encoder_core.sv]
// ----------------------------------------------------------------------------
// base64_stream_encoder_core
// Base64 encoder: bytes in, characters out, with selectable alphabet and
// optional padding on a flushed partial group.
// ----------------------------------------------------------------------------
//  Channel   Handshake           Payload
//  input     push / full         byte_item (cmd, data_byte)
//  result    empty / pop         char_item (out_char, last)
//  config    cfg_valid/cfg_ready cfg_index, cfg_data
//
// An input item is taken every cycle while the group queue has room; the back
// end turns each group into characters, four for three data bytes and up to
// four for a flush. The character rate of the back end sets the sustained
// throughput. Reset empties the held bytes, the group queue and the output
// register. The front stalls only on a full group queue; the back stalls only
// while the output register is not taken.
// ----------------------------------------------------------------------------
module base64_stream_encoder_core #(
	parameter int unsigned GqDepth = b64enc_pkg::GqDepthDefault
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  b64enc_pkg::b64_in_t               byte_item,
	output logic                              empty,
	input  logic                              pop,
	output b64enc_pkg::b64_out_t              char_item,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [b64enc_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic                              cfg_data
);
	import b64enc_pkg::*;

	b64_cfg_t   cfg_q;
	logic       gq_wr;
	logic       gq_rd;
	logic       gq_full;
	logic       gq_empty;
	b64_group_t gq_wdata;
	b64_group_t gq_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.url_alphabet <= 1'b0;
			cfg_q.pad_enable   <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_URL_ALPHABET) begin
				cfg_q.url_alphabet <= cfg_data;
			end
			if (cfg_index == REG_PAD_ENABLE) begin
				cfg_q.pad_enable <= cfg_data;
			end
		end
	end

	b64enc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.byte_item (byte_item),
		.gq_wr     (gq_wr),
		.gq_wdata  (gq_wdata),
		.gq_full   (gq_full)
	);

	b64enc_gq #(
		.Depth (GqDepth)
	) u_gq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (gq_wr),
		.wdata    (gq_wdata),
		.rd       (gq_rd),
		.rdata    (gq_rdata),
		.gq_full  (gq_full),
		.gq_empty (gq_empty)
	);

	b64enc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.gq_rdata  (gq_rdata),
		.gq_empty  (gq_empty),
		.gq_rd     (gq_rd),
		.empty     (empty),
		.pop       (pop),
		.char_item (char_item)
	);

endmodule

[tb/base64_stream_encoder_checker.sv]
// ----------------------------------------------------------------------------
// base64_stream_encoder_checker
// Watches the input, result and register channels of the encoder, predicts
// the character stream from the accepted input items and compares every
// accepted character, in order, with the prediction.
// ----------------------------------------------------------------------------
module base64_stream_encoder_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  logic                            full,
	input  b64enc_pkg::b64_in_t             byte_item,
	input  logic                            empty,
	input  logic                            pop,
	input  b64enc_pkg::b64_out_t            char_item,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [b64enc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic                            cfg_data,
	output int                              mismatches,
	output int                              pending
);
	import b64enc_pkg::*;

	logic       url_sel;
	logic       pad_on;
	logic [7:0] held_lo;
	logic [7:0] held_hi;
	logic [1:0] held_n;
	b64_out_t   expected_chars[$];
	b64_out_t   oldest;

	function automatic logic [6:0] sextet_to_ascii(input logic [5:0] v);
		logic [6:0] ch;
		if (v < 6'd26) begin
			ch = 7'h41 + {1'b0, v};
		end else if (v < 6'd52) begin
			ch = 7'h61 + {1'b0, v} - 7'd26;
		end else if (v < 6'd62) begin
			ch = 7'h30 + {1'b0, v} - 7'd52;
		end else if (v == 6'd62) begin
			ch = url_sel ? CHAR_DASH : CHAR_PLUS;
		end else begin
			ch = url_sel ? CHAR_UNDER : CHAR_SLASH;
		end
		return ch;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch on %s: got %0h, expected %0h", what, got, want);
		mismatches++;
	endtask

	// The second byte must be zero when only one byte is in the group.
	task automatic queue_group(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input int n);
		logic [6:0] chars[4];
		int         k;
		int         i;
		b64_out_t   r;
		chars[0] = sextet_to_ascii(b0[7:2]);
		chars[1] = sextet_to_ascii({b0[1:0], b1[7:4]});
		k = 2;
		if (n > 1) begin
			chars[k] = sextet_to_ascii({b1[3:0], b2[7:6]});
			k++;
		end else if (pad_on) begin
			chars[k] = PAD_CHAR;
			k++;
		end
		if (n > 2) begin
			chars[k] = sextet_to_ascii(b2[5:0]);
			k++;
		end else if (pad_on) begin
			chars[k] = PAD_CHAR;
			k++;
		end
		for (i = 0; i < k; i++) begin
			r.out_char = chars[i];
			r.last = (i == k - 1);
			expected_chars = {expected_chars, r};
		end
	endtask

	task automatic predict_chars(input b64_in_t it);
		logic [1:0] n;
		n = (held_n == 2'd3) ? 2'd0 : held_n;
		if (it.cmd == CMD_FLUSH) begin
			held_n = 2'd0;
			if (n != 2'd0)
				queue_group(held_lo, (n == 2'd2) ? held_hi : 8'h00, 8'h00, n);
		end else if (n < 2'd2) begin
			if (n == 2'd0)
				held_lo = it.data_byte;
			else
				held_hi = it.data_byte;
			held_n = n + 2'd1;
		end else begin
			queue_group(held_lo, held_hi, it.data_byte, 3);
			held_n = 2'd0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			url_sel = 1'b0;
			pad_on = 1'b1;
			held_n = 2'd0;
			expected_chars.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			// Results first: a character taken now never belongs to an item taken now.
			if (pop && !empty) begin
				if (expected_chars.size() == 0) begin
					report_mismatch("unexpected character", char_item.out_char, 0);
				end else begin
					oldest = expected_chars[0];
					expected_chars.delete(0);
					if (char_item.out_char !== oldest.out_char)
						report_mismatch("out_char", char_item.out_char, oldest.out_char);
					if (char_item.last !== oldest.last)
						report_mismatch("last", char_item.last, oldest.last);
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_URL_ALPHABET)
					url_sel = cfg_data;
				else if (cfg_index == REG_PAD_ENABLE)
					pad_on = cfg_data;
			end
			if (push && !full)
				predict_chars(byte_item);
			pending = expected_chars.size();
		end
	end

endmodule

[tb/base64_stream_encoder_core_tb.sv]
// ----------------------------------------------------------------------------
// base64_stream_encoder_core_tb
// Drives byte and flush items and register writes into the encoder core, with
// random idle bursts on both sides, and gives the verdict from the checker's
// mismatch and pending counts.
// ----------------------------------------------------------------------------
module base64_stream_encoder_core_tb;
	import b64enc_pkg::*;

	localparam logic [CfgIdxW-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_SPARE_3 = 2'd3;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 48;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                push = 1'b0;
	logic                full;
	b64_in_t             byte_item = '0;
	logic                empty;
	logic                pop = 1'b0;
	b64_out_t            char_item;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic                cfg_data = 1'b0;
	logic                calm = 1'b0;
	int                  mismatches;
	int                  pending;
	int                  idle_cycles = 0;

	base64_stream_encoder_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.byte_item(byte_item),
		.empty(empty),
		.pop(pop),
		.char_item(char_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	base64_stream_encoder_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.byte_item(byte_item),
		.empty(empty),
		.pop(pop),
		.char_item(char_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.pending(pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Receiver: takes characters, with stall bursts except in the calm tail.
	always begin
		@(negedge clk);
		if (calm || $urandom_range(0, 3) != 0) begin
			pop <= 1'b1;
		end else begin
			pop <= 1'b0;
			repeat ($urandom_range(0, 12)) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("base64_stream_encoder_core test failed");
				$finish;
			end
		end
	end

	// Called at a falling edge; returns at a falling edge after the item is taken.
	task automatic send_item(input logic cmd, input logic [7:0] data_byte);
		if (!calm && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		push <= 1'b1;
		byte_item <= '{cmd: cmd, data_byte: data_byte};
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	task automatic send_flush();
		send_item(CMD_FLUSH, 8'($urandom));
	endtask

	// The sender holds off until every predicted character has been taken.
	task automatic wait_for_drain();
		push <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic val);
		wait_for_drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random_item();
		logic [7:0] b;
		if ($urandom_range(0, 7) == 0)
			b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		else
			b = 8'($urandom);
		if ($urandom_range(0, 5) == 0)
			send_flush();
		else
			send_item(CMD_DATA, b);
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, reset configuration: standard alphabet, padding on.
		send_flush();
		send_item(CMD_DATA, 8'h00);
		send_item(CMD_DATA, 8'h00);
		send_item(CMD_DATA, 8'h00);
		send_item(CMD_DATA, 8'hFF);
		send_item(CMD_DATA, 8'hFF);
		send_item(CMD_DATA, 8'hFF);
		// Every sextet of this group is 62.
		send_item(CMD_DATA, 8'hFB);
		send_item(CMD_DATA, 8'hEF);
		send_item(CMD_DATA, 8'hBE);
		send_item(CMD_DATA, 8'hA5);
		send_flush();
		send_item(CMD_DATA, 8'h5A);
		send_item(CMD_DATA, 8'hC3);
		send_flush();
		send_flush();

		write_reg(REG_URL_ALPHABET, 1'b1);
		send_item(CMD_DATA, 8'hFF);
		send_item(CMD_DATA, 8'hFB);
		send_item(CMD_DATA, 8'hEF);
		write_reg(REG_PAD_ENABLE, 1'b0);
		send_item(CMD_DATA, 8'h3C);
		send_flush();
		send_item(CMD_DATA, 8'hFE);
		send_item(CMD_DATA, 8'hFF);
		send_flush();

		// The alphabet in force when the third byte arrives applies, not the
		// one in force when the first two were taken.
		send_item(CMD_DATA, 8'hFF);
		send_item(CMD_DATA, 8'hFF);
		write_reg(REG_URL_ALPHABET, 1'b0);
		write_reg(REG_SPARE_2, 1'b1);
		write_reg(REG_SPARE_3, 1'b1);
		send_item(CMD_DATA, 8'hFF);
		send_flush();

		for (int p = 0; p < PHASES; p++) begin
			if (p < 4) begin
				write_reg(REG_URL_ALPHABET, p[0]);
				write_reg(REG_PAD_ENABLE, p[1]);
			end else begin
				write_reg(REG_URL_ALPHABET, 1'($urandom));
				write_reg(REG_PAD_ENABLE, 1'($urandom));
				if ($urandom_range(0, 1))
					write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, 1'($urandom));
			end
			if (p == PHASES - 1)
				calm = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 2 && i == PHASE_ITEMS / 2)
					wait_for_drain();
				send_random_item();
			end
		end

		push <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("base64_stream_encoder_core test passed");
		else
			$display("base64_stream_encoder_core test failed");
		$finish;
	end

endmodule
